/* src/cmdseg_pkg.sv */
// Package for the CAN command segmenter: frame record, header phase type and
// size constants. Used by every module of the block; depends on nothing.
package cmdseg_pkg;

    localparam int PAYLOAD_PER_FRAME_DEF = 7;  // default payload bytes per frame
    localparam int PAYLOAD_MAX           = 7;  // payload slots in one CAN frame
    localparam int FRAME_BYTES           = 8;
    localparam int FILL_W                = 3;
    localparam int SEQ_W                 = 8;
    localparam int ID_W                  = 16;
    localparam int LEN_W                 = 4;

    typedef enum logic [1:0] {
        PH_ID      = 2'd0,
        PH_FUNC    = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef struct packed {
        logic [ID_W-1:0]                extended_id;
        logic [LEN_W-1:0]               frame_length;
        logic [FRAME_BYTES-1:0][7:0]    data;
        logic                           final_frame;
    } t_frame;

endpackage

/* src/cmdseg_gather.sv */
// Header tracking, payload gathering and frame assembly for one byte transfer.
// Depends on cmdseg_pkg.
module cmdseg_gather #(
    parameter int PAYLOAD_PER_FRAME = cmdseg_pkg::PAYLOAD_PER_FRAME_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output logic                o_emit,
    output cmdseg_pkg::t_frame  o_frame
);

    localparam int IDX_W = (PAYLOAD_PER_FRAME > 1) ? $clog2(PAYLOAD_PER_FRAME) : 1;

    cmdseg_pkg::t_phase                   r_phase, n_phase;
    logic [7:0]                           r_dev;
    logic [7:0]                           r_func;
    logic [cmdseg_pkg::FILL_W-1:0]        r_fill, n_fill;
    logic [cmdseg_pkg::SEQ_W-1:0]         r_seq, n_seq;
    logic [7:0]                           r_buf [PAYLOAD_PER_FRAME];
    logic [cmdseg_pkg::FILL_W-1:0]        fill_new;
    logic                                 emit;

    // Next phase
    always_comb begin
        case (r_phase)
            cmdseg_pkg::PH_ID:      n_phase = cmdseg_pkg::PH_FUNC;
            cmdseg_pkg::PH_FUNC:    n_phase = cmdseg_pkg::PH_PAYLOAD;
            cmdseg_pkg::PH_PAYLOAD: n_phase = cmdseg_pkg::PH_PAYLOAD;
            default:                n_phase = cmdseg_pkg::PH_PAYLOAD;
        endcase
        if (i_last) begin
            n_phase = cmdseg_pkg::PH_ID;
        end
    end

    // Phase outputs: frame decision and counters
    always_comb begin
        fill_new = r_fill + cmdseg_pkg::FILL_W'(1);
        emit     = 1'b0;
        n_fill   = r_fill;
        n_seq    = r_seq;
        case (r_phase)
            cmdseg_pkg::PH_PAYLOAD: begin
                emit   = (fill_new >= cmdseg_pkg::FILL_W'(PAYLOAD_PER_FRAME)) || i_last;
                n_fill = emit ? '0 : fill_new;
                n_seq  = emit ? r_seq + cmdseg_pkg::SEQ_W'(1) : r_seq;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        if (i_last) begin
            n_fill = '0;
            n_seq  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cmdseg_pkg::PH_ID;
            r_dev   <= '0;
            r_func  <= '0;
            r_fill  <= '0;
            r_seq   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_seq   <= n_seq;
            if (r_phase == cmdseg_pkg::PH_ID) begin
                r_dev <= i_byte;
            end
            if (r_phase == cmdseg_pkg::PH_FUNC) begin
                r_func <= i_byte;
            end
        end
    end

    // Payload slots hold no reset: only slots below the fill count go out
    always_ff @(posedge i_clk) begin
        if (i_accept && r_phase == cmdseg_pkg::PH_PAYLOAD) begin
            r_buf[r_fill[IDX_W-1:0]] <= i_byte;
        end
    end

    assign o_emit                 = i_accept && emit;
    assign o_frame.extended_id    = {r_dev, r_seq};
    assign o_frame.frame_length   = cmdseg_pkg::LEN_W'(fill_new) + cmdseg_pkg::LEN_W'(1);
    assign o_frame.final_frame    = i_last;
    assign o_frame.data[0]        = r_func;

    // Frame byte k carries payload slot k-1; the byte arriving now is folded in
    for (genvar k = 1; k < cmdseg_pkg::FRAME_BYTES; k++) begin : g_byte
        if (k - 1 < PAYLOAD_PER_FRAME) begin : g_slot
            assign o_frame.data[k] =
                (cmdseg_pkg::FILL_W'(k - 1) == r_fill) ? i_byte :
                (cmdseg_pkg::FILL_W'(k - 1) <  r_fill) ? r_buf[k - 1] : 8'h00;
        end else begin : g_pad
            assign o_frame.data[k] = 8'h00;
        end
    end

endmodule

/* src/cmdseg_outbuf.sv */
// Result register with a skid stage for the frame channel.
// Depends on cmdseg_pkg.
module cmdseg_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cmdseg_pkg::t_frame  i_frame,
    output logic                o_space,
    output logic                o_valid,
    input  logic                i_ready,
    output cmdseg_pkg::t_frame  o_frame
);

    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;
    cmdseg_pkg::t_frame r_out, n_out;
    cmdseg_pkg::t_frame r_skid, n_skid;
    logic               drain;

    always_comb begin
        drain        = r_out_valid && i_ready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (drain) begin
            n_out_valid  = r_skid_valid;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        if (i_push) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = i_frame;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_frame = r_out;

endmodule

/* src/can_command_segmenter_unit.sv */
// Top level of the CAN command segmenter: byte channel in, frame channel out.
// Depends on cmdseg_pkg, cmdseg_gather and cmdseg_outbuf.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  byte     | in        | i_valid / o_ready  | i_data_byte, i_end_of_command
//  frame    | out       | o_valid / i_ready  | o_extended_id, o_frame_length,
//           |           |                    | o_byte0..o_byte7, o_final_frame
//
// One byte transfer per cycle while the skid stage is free; a finished frame is
// registered in the result register, or in the skid stage while that holds a frame.
// Reset (synchronous, active low) returns the header phase to the device id
// and empties the output stages.
// A stalled frame sits in the result register while a skid stage takes one
// more; byte transfers stop only while both hold a frame.
module can_command_segmenter_unit #(
    parameter int PAYLOAD_PER_FRAME = cmdseg_pkg::PAYLOAD_PER_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_command,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_extended_id,
    output logic [3:0]  o_frame_length,
    output logic [7:0]  o_byte0,
    output logic [7:0]  o_byte1,
    output logic [7:0]  o_byte2,
    output logic [7:0]  o_byte3,
    output logic [7:0]  o_byte4,
    output logic [7:0]  o_byte5,
    output logic [7:0]  o_byte6,
    output logic [7:0]  o_byte7,
    output logic        o_final_frame
);

    logic               accept;
    logic               emit;
    logic               space;
    cmdseg_pkg::t_frame frame_new;
    cmdseg_pkg::t_frame frame_out;

    // A byte transfer happens whenever a byte is offered and the skid stage is free
    assign o_ready = space;
    assign accept  = i_valid && space;

    // Track header, gather payload, assemble the frame for this byte
    cmdseg_gather #(
        .PAYLOAD_PER_FRAME (PAYLOAD_PER_FRAME)
    ) u_gather (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_data_byte),
        .i_last   (i_end_of_command),
        .o_emit   (emit),
        .o_frame  (frame_new)
    );

    // Hold finished frames until the frame transfer completes
    cmdseg_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_frame (frame_new),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_frame (frame_out)
    );

    assign o_extended_id  = frame_out.extended_id;
    assign o_frame_length = frame_out.frame_length;
    assign o_byte0        = frame_out.data[0];
    assign o_byte1        = frame_out.data[1];
    assign o_byte2        = frame_out.data[2];
    assign o_byte3        = frame_out.data[3];
    assign o_byte4        = frame_out.data[4];
    assign o_byte5        = frame_out.data[5];
    assign o_byte6        = frame_out.data[6];
    assign o_byte7        = frame_out.data[7];
    assign o_final_frame  = frame_out.final_frame;

endmodule

/* src/cmdseg_checker.sv */
// Port-level checks for the CAN command segmenter, bound to the top level.
// Depends on cmdseg_pkg and can_command_segmenter_unit.
module cmdseg_checker #(
    parameter int PAYLOAD_PER_FRAME = cmdseg_pkg::PAYLOAD_PER_FRAME_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [3:0]  o_frame_length,
    input  logic [7:0]  o_byte7,
    input  logic        o_final_frame
);

    // Hold a stalled frame
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("frame dropped while stalled");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_frame_length >= 4'd2) && (o_frame_length <= 4'd8))
        else $error("frame length out of range");

    // A frame that does not end the command carries a full group
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_frame |-> o_frame_length == 4'(PAYLOAD_PER_FRAME + 1))
        else $error("short frame before end of command");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_length != 4'd8 |-> o_byte7 == 8'h00)
        else $error("padding byte not zero");

endmodule

bind can_command_segmenter_unit cmdseg_checker #(
    .PAYLOAD_PER_FRAME (PAYLOAD_PER_FRAME)
) u_cmdseg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_frame_length (o_frame_length),
    .o_byte7        (o_byte7),
    .o_final_frame  (o_final_frame)
);

/* sim/tb_top.sv */
// Self-checking testbench for can_command_segmenter_unit: byte stream in, CAN frames out.
// Depends on cmdseg_pkg for the frame record, the header phase type and the size constants.
`timescale 1ns / 1ps
module tb_top;

    // Quiet cycles (no transfer on either channel) tolerated before giving up
    localparam int QUIET_LIMIT  = 4000;
    // Cycles to keep watching once nothing more is expected
    localparam int SETTLE_CYCLES = 20;
    // Random bytes per idling phase
    localparam int RANDOM_BYTES = 140;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_end_of_command = 1'b0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic [15:0] o_extended_id;
    logic [3:0]  o_frame_length;
    logic [7:0]  o_byte0, o_byte1, o_byte2, o_byte3;
    logic [7:0]  o_byte4, o_byte5, o_byte6, o_byte7;
    logic        o_final_frame;

    can_command_segmenter_unit DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_command (i_end_of_command),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_extended_id    (o_extended_id),
        .o_frame_length   (o_frame_length),
        .o_byte0          (o_byte0),
        .o_byte1          (o_byte1),
        .o_byte2          (o_byte2),
        .o_byte3          (o_byte3),
        .o_byte4          (o_byte4),
        .o_byte5          (o_byte5),
        .o_byte6          (o_byte6),
        .o_byte7          (o_byte7),
        .o_final_frame    (o_final_frame)
    );

    // One row of the directed table. Where fixed_exp is set, the frame (or the
    // absence of one) is typed in by hand; otherwise the segmenter model decides.
    typedef struct {
        logic [7:0]         data;
        logic               eoc;
        bit                 fixed_exp;
        bit                 has_frame;
        cmdseg_pkg::t_frame frame;
    } t_stim_row;

    t_stim_row          directed_rows[$];
    cmdseg_pkg::t_frame pending_frames[$];   // frames owed by the block, oldest first

    // Expectation attached to the byte currently on the input channel
    bit                 cur_fixed;
    bit                 cur_has_frame;
    cmdseg_pkg::t_frame cur_frame;

    int        in_idle_pct  = 0;
    int        out_idle_pct = 0;
    int        errors       = 0;
    int        quiet_cycles = 0;

    // Segmenter model state
    cmdseg_pkg::t_phase               seg_phase;
    logic [7:0]                       seg_dev_id;
    logic [7:0]                       seg_func;
    logic [7:0]                       seg_buf [cmdseg_pkg::PAYLOAD_MAX];
    logic [cmdseg_pkg::FILL_W-1:0]    seg_fill;
    logic [cmdseg_pkg::SEQ_W-1:0]     seg_seq;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Model of the segmenter: advance on one accepted byte and hand back the
    // frame it completes, if any.
    task automatic segment_byte(input logic [7:0] b, input logic eoc,
                                output bit made, output cmdseg_pkg::t_frame f);
        made = 1'b0;
        f    = '0;
        case (seg_phase)
            cmdseg_pkg::PH_ID: begin
                seg_dev_id = b;
                seg_phase  = cmdseg_pkg::PH_FUNC;
            end
            cmdseg_pkg::PH_FUNC: begin
                seg_func  = b;
                seg_phase = cmdseg_pkg::PH_PAYLOAD;
            end
            default: begin
                if (seg_fill < cmdseg_pkg::PAYLOAD_MAX) begin
                    seg_buf[seg_fill] = b;
                    seg_fill          = seg_fill + 1'b1;
                end
                // Close the frame on a full group or on the last byte; one frame either way
                if (seg_fill >= cmdseg_pkg::PAYLOAD_PER_FRAME_DEF || eoc) begin
                    f.extended_id  = {seg_dev_id, seg_seq};
                    f.frame_length = cmdseg_pkg::LEN_W'(seg_fill) + 1'b1;
                    f.data[0]      = seg_func;
                    for (int k = 1; k < cmdseg_pkg::FRAME_BYTES; k++)
                        f.data[k] = (k <= seg_fill) ? seg_buf[k-1] : 8'h00;
                    f.final_frame  = eoc;
                    made           = 1'b1;
                    seg_seq        = seg_seq + 1'b1;
                    seg_fill       = '0;
                end
            end
        endcase
        if (eoc) begin
            seg_phase = cmdseg_pkg::PH_ID;
            seg_fill  = '0;
            seg_seq   = '0;
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic eoc, input bit fixed,
                           input bit has_frame, input cmdseg_pkg::t_frame f);
        t_stim_row r;
        r.data      = b;
        r.eoc       = eoc;
        r.fixed_exp = fixed;
        r.has_frame = has_frame;
        r.frame     = f;
        directed_rows.push_back(r);
    endtask

    // Offer one byte on the input channel. Entered and left at a falling edge.
    task automatic put_byte(input logic [7:0] b, input logic eoc, input bit fixed,
                            input bit has_frame, input cmdseg_pkg::t_frame f);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_fixed        = fixed;
        cur_has_frame    = has_frame;
        cur_frame        = f;
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_end_of_command <= eoc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Send one command of len bytes (id, function code, payload) with random content
    task automatic put_command(input int len);
        for (int n = 0; n < len; n++)
            put_byte(8'($urandom_range(0, 255)), n == len - 1, 1'b0, 1'b0, '0);
    endtask

    // Random commands: mostly well formed with payload, some exact multiples
    // of a full group, and a sprinkling of too-short and payload-free ones.
    task automatic put_random_commands(input int budget);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                len = 1;
            else if (pick < 12)
                len = 2;
            else if (pick < 24)
                len = 2 + cmdseg_pkg::PAYLOAD_MAX * $urandom_range(1, 3);
            else
                len = 2 + $urandom_range(1, 20);
            put_command(len);
            sent += len;
        end
    endtask

    // Receiver: stall at random according to the current phase
    always @(negedge i_clk) begin
        i_ready <= (out_idle_pct == 0) || ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Monitor: predict on every byte transfer, check every frame transfer, and
    // watch for a stuck block.
    always @(posedge i_clk) begin : monitor_p
        bit                 made;
        cmdseg_pkg::t_frame pred;
        cmdseg_pkg::t_frame seen;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                segment_byte(i_data_byte, i_end_of_command, made, pred);
                // Hand-typed rows override the model, which still tracks state
                if (cur_fixed) begin
                    if (cur_has_frame) pending_frames.push_back(cur_frame);
                end else if (made) begin
                    pending_frames.push_back(pred);
                end
            end

            if (o_valid && i_ready) begin
                seen.extended_id  = o_extended_id;
                seen.frame_length = o_frame_length;
                seen.data         = {o_byte7, o_byte6, o_byte5, o_byte4,
                                     o_byte3, o_byte2, o_byte1, o_byte0};
                seen.final_frame  = o_final_frame;
                if (pending_frames.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, got id %h len %0d",
                             $time, seen.extended_id, seen.frame_length);
                    errors++;
                end else begin
                    pred = pending_frames.pop_front();
                    if (seen.extended_id !== pred.extended_id) begin
                        $display("%0t: extended_id expected %h, got %h",
                                 $time, pred.extended_id, seen.extended_id);
                        errors++;
                    end
                    if (seen.frame_length !== pred.frame_length) begin
                        $display("%0t: frame_length expected %0d, got %0d",
                                 $time, pred.frame_length, seen.frame_length);
                        errors++;
                    end
                    for (int k = 0; k < cmdseg_pkg::FRAME_BYTES; k++) begin
                        if (seen.data[k] !== pred.data[k]) begin
                            $display("%0t: byte%0d expected %h, got %h",
                                     $time, k, pred.data[k], seen.data[k]);
                            errors++;
                        end
                    end
                    if (seen.final_frame !== pred.final_frame) begin
                        $display("%0t: final_frame expected %b, got %b",
                                 $time, pred.final_frame, seen.final_frame);
                        errors++;
                    end
                end
            end

            // Count cycles with no transfer at all; give up when too many pass
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d frames outstanding",
                         $time, quiet_cycles, pending_frames.size());
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin : main_p
        seg_phase  = cmdseg_pkg::PH_ID;
        seg_dev_id = '0;
        seg_func   = '0;
        seg_fill   = '0;
        seg_seq    = '0;
        cur_fixed  = 1'b0;
        cur_has_frame = 1'b0;
        cur_frame  = '0;

        // Too short: command ends on its device id
        add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
        // No payload: command ends on its function code
        add_row(8'hAB, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h12, 1'b1, 1'b1, 1'b0, '0);
        // Single payload byte, top device id, zero function code
        add_row(8'hFF, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b1, 1'b1,
                cmdseg_pkg::t_frame'{16'hFF00, 4'd2, 64'h0000_0000_0000_FF00, 1'b1});
        // Full group on the last byte: one final frame, no empty one after it
        add_row(8'h00, 1'b0, 1'b1, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b1, 1'b0, '0);
        for (int k = 1; k < cmdseg_pkg::PAYLOAD_MAX; k++)
            add_row(8'(k), 1'b0, 1'b1, 1'b0, '0);
        add_row(8'h07, 1'b1, 1'b1, 1'b1,
                cmdseg_pkg::t_frame'{16'h0000, 4'd8, 64'h0706_0504_0302_01FF, 1'b1});
        // Two frames: a full group, then a short final one with padding
        add_row(8'h5A, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hA5, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h80, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h7F, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h55, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hAA, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFE, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h33, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hCC, 1'b1, 1'b0, 1'b0, '0);

        // Hold reset, then release it at a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender idles lightly, receiver heavily
        in_idle_pct  = 15;
        out_idle_pct = 48;
        foreach (directed_rows[n])
            put_byte(directed_rows[n].data, directed_rows[n].eoc, directed_rows[n].fixed_exp,
                     directed_rows[n].has_frame, directed_rows[n].frame);
        put_random_commands(RANDOM_BYTES);

        // Swap the pressure round
        in_idle_pct  = 48;
        out_idle_pct = 15;
        put_random_commands(RANDOM_BYTES);

        // No idling on either side
        in_idle_pct  = 0;
        out_idle_pct = 0;
        put_random_commands(RANDOM_BYTES);

        i_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
src/cmdseg_pkg.sv
src/cmdseg_gather.sv
src/cmdseg_outbuf.sv
src/can_command_segmenter_unit.sv
src/cmdseg_checker.sv
sim/tb_top.sv
